FILE: rtl/dds_tw_pkg.sv
// Shared types and constants for the DDS tuning word and band select block.
`default_nettype none
package dds_tw_pkg;

   localparam int FREQ_W    = 27;
   localparam int CRYSTAL_W = 30;
   localparam int ADDR_W    = 6;
   localparam int BAND_W    = 6;
   localparam int BYTE_W    = 8;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [CRYSTAL_W-1:0] CRYSTAL_RESET = 30'd200000000;

   localparam logic [FREQ_W-1:0] BAND_T0 = 27'd2250000;
   localparam logic [FREQ_W-1:0] BAND_T1 = 27'd5500000;
   localparam logic [FREQ_W-1:0] BAND_T2 = 27'd11000000;
   localparam logic [FREQ_W-1:0] BAND_T3 = 27'd22000000;
   localparam logic [FREQ_W-1:0] BAND_T4 = 27'd37500000;

   localparam logic [BAND_W-1:0] BAND_0 = 6'b000001;
   localparam logic [BAND_W-1:0] BAND_1 = 6'b000010;
   localparam logic [BAND_W-1:0] BAND_2 = 6'b000100;
   localparam logic [BAND_W-1:0] BAND_3 = 6'b001000;
   localparam logic [BAND_W-1:0] BAND_4 = 6'b010000;
   localparam logic [BAND_W-1:0] BAND_5 = 6'b100000;

   localparam logic [ADDR_W-1:0] LATCH_ADDR     = 6'd0;
   localparam logic [ADDR_W-1:0] FIRST_DDS_ADDR = 6'd4;

   localparam logic TARGET_LATCH = 1'b0;
   localparam logic TARGET_DDS   = 1'b1;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [BAND_W-1:0] band;
      logic              sat;
   } entry_type;

   typedef struct packed {
      logic empty;
   } queue_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_BAND = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_HOLD = 4'b1000
   } back_state_type;

endpackage
`default_nettype wire

FILE: rtl/dds_tw_front.sv
// Front end: crystal register, band classification and saturation check.
`default_nettype none
module dds_tw_front (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [dds_tw_pkg::CRYSTAL_W-1:0]     csr_wdata,
   input  wire  [dds_tw_pkg::FREQ_W-1:0]        freq_hz,
   output logic [dds_tw_pkg::CRYSTAL_W-1:0]     crystal_hz,
   output dds_tw_pkg::entry_type                entry
);

   logic [dds_tw_pkg::CRYSTAL_W-1:0] crystal_ff;
   logic [dds_tw_pkg::CRYSTAL_W-1:0] crystal_in;

   assign csr_ready  = 1'b1;
   assign crystal_hz = crystal_ff;

   always_comb begin
      crystal_in = crystal_ff;
      if (csr_valid) begin
         crystal_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crystal_ff <= dds_tw_pkg::CRYSTAL_RESET;
      end else begin
         crystal_ff <= crystal_in;
      end
   end

   always_comb begin
      entry.freq = freq_hz;
      entry.sat  = ({3'b000, freq_hz} >= crystal_ff);
      if (freq_hz <= dds_tw_pkg::BAND_T0) begin
         entry.band = dds_tw_pkg::BAND_0;
      end else if (freq_hz <= dds_tw_pkg::BAND_T1) begin
         entry.band = dds_tw_pkg::BAND_1;
      end else if (freq_hz <= dds_tw_pkg::BAND_T2) begin
         entry.band = dds_tw_pkg::BAND_3;   // board wiring swaps bands 2 and 3
      end else if (freq_hz <= dds_tw_pkg::BAND_T3) begin
         entry.band = dds_tw_pkg::BAND_2;
      end else if (freq_hz <= dds_tw_pkg::BAND_T4) begin
         entry.band = dds_tw_pkg::BAND_4;
      end else begin
         entry.band = dds_tw_pkg::BAND_5;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/dds_tw_queue.sv
// Short queue of classified items between front and back.
`default_nettype none
module dds_tw_queue (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push,
   output logic                        full,
   input  dds_tw_pkg::entry_type       wr_entry,
   output dds_tw_pkg::queue_ctl_type   ctl_out,
   input  wire                         pop,
   output dds_tw_pkg::entry_type       rd_entry
);

   localparam int DEPTH = dds_tw_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   dds_tw_pkg::entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full          = (count_ff == CW'(DEPTH));
   assign ctl_out.empty = (count_ff == '0);
   assign do_push       = push && !full;
   assign do_pop        = pop && !ctl_out.empty;
   assign rd_entry      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/dds_tw_back.sv
// Back end: bit-serial long division and sequencing of the result beats.
`default_nettype none
module dds_tw_back #(
   parameter int WORD_BYTES = 6
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  [dds_tw_pkg::CRYSTAL_W-1:0]     crystal_hz,
   input  dds_tw_pkg::queue_ctl_type            q_ctl,
   input  dds_tw_pkg::entry_type                q_entry,
   output logic                                 q_pop,
   output logic                                 rsp_empty,
   input  wire                                  rsp_pop,
   output logic                                 rsp_target,
   output logic [dds_tw_pkg::ADDR_W-1:0]        rsp_reg_addr,
   output logic [dds_tw_pkg::BYTE_W-1:0]        rsp_data_byte,
   output logic                                 rsp_last
);

   localparam int CRW = dds_tw_pkg::CRYSTAL_W;
   localparam int IW  = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;

   dds_tw_pkg::back_state_type state_ff, state_in;

   logic [CRW-1:0]                  rem_ff, rem_in;
   logic [dds_tw_pkg::BYTE_W-1:0]   quot_ff, quot_in;
   logic [2:0]                      bit_ff, bit_in;
   logic [IW-1:0]                   idx_ff, idx_in;
   logic                            sat_ff, sat_in;
   logic [dds_tw_pkg::BAND_W-1:0]   band_ff, band_in;

   logic                            out_valid_ff, out_valid_in;
   logic                            out_target_ff, out_target_in;
   logic [dds_tw_pkg::ADDR_W-1:0]   out_addr_ff, out_addr_in;
   logic [dds_tw_pkg::BYTE_W-1:0]   out_data_ff, out_data_in;
   logic                            out_last_ff, out_last_in;

   logic                            slot_free;
   logic [CRW:0]                    shifted;
   logic                            take;
   logic                            last_byte;

   assign slot_free     = !out_valid_ff || rsp_pop;
   assign shifted       = {rem_ff, 1'b0};
   assign take          = (shifted >= {1'b0, crystal_hz});
   assign last_byte     = (idx_ff == IW'(WORD_BYTES - 1));

   assign rsp_empty     = !out_valid_ff;
   assign rsp_target    = out_target_ff;
   assign rsp_reg_addr  = out_addr_ff;
   assign rsp_data_byte = out_data_ff;
   assign rsp_last      = out_last_ff;

   always_comb begin
      state_in      = state_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      bit_in        = bit_ff;
      idx_in        = idx_ff;
      sat_in        = sat_ff;
      band_in       = band_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      out_target_in = out_target_ff;
      out_addr_in   = out_addr_ff;
      out_data_in   = out_data_ff;
      out_last_in   = out_last_ff;
      q_pop         = 1'b0;
      case (state_ff)
         dds_tw_pkg::ST_IDLE: begin
            if (!q_ctl.empty) begin
               q_pop    = 1'b1;
               rem_in   = {3'b000, q_entry.freq};
               sat_in   = q_entry.sat;
               band_in  = q_entry.band;
               idx_in   = '0;
               bit_in   = '0;
               state_in = dds_tw_pkg::ST_BAND;
            end
         end
         dds_tw_pkg::ST_BAND: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_target_in = dds_tw_pkg::TARGET_LATCH;
               out_addr_in   = dds_tw_pkg::LATCH_ADDR;
               out_data_in   = {2'b00, band_ff};
               out_last_in   = 1'b0;
               state_in      = dds_tw_pkg::ST_DIV;
            end
         end
         dds_tw_pkg::ST_DIV: begin
            if (sat_ff) begin
               quot_in  = '1;
               state_in = dds_tw_pkg::ST_HOLD;
            end else begin
               rem_in  = take ? CRW'(shifted - {1'b0, crystal_hz}) : shifted[CRW-1:0];
               quot_in = {quot_ff[dds_tw_pkg::BYTE_W-2:0], take};
               bit_in  = bit_ff + 1'b1;
               if (bit_ff == 3'd7) begin
                  state_in = dds_tw_pkg::ST_HOLD;
               end
            end
         end
         dds_tw_pkg::ST_HOLD: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_target_in = dds_tw_pkg::TARGET_DDS;
               out_addr_in   = dds_tw_pkg::FIRST_DDS_ADDR + dds_tw_pkg::ADDR_W'(idx_ff);
               out_data_in   = quot_ff;
               out_last_in   = last_byte;
               bit_in        = '0;
               if (last_byte) begin
                  state_in = dds_tw_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = dds_tw_pkg::ST_DIV;
               end
            end
         end
         default: begin
            state_in = dds_tw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dds_tw_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      bit_ff        <= bit_in;
      idx_ff        <= idx_in;
      sat_ff        <= sat_in;
      band_ff       <= band_in;
      out_target_ff <= out_target_in;
      out_addr_ff   <= out_addr_in;
      out_data_ff   <= out_data_in;
      out_last_ff   <= out_last_in;
   end

endmodule
`default_nettype wire

FILE: rtl/dds_tuning_word_and_band_select_core.sv
// Top level of the DDS tuning word and band select block.
//
// Input queue port: req_push / req_full with req_freq_hz (whole hertz).
// Each accepted beat yields 1 + WORD_BYTES result beats on the rsp port,
// read like a queue with rsp_empty / rsp_pop: first a band latch write
// (target 0, address 0, one-hot band), then the tuning word
// floor(freq * 2^(8*WORD_BYTES) / crystal) MSB first at DDS addresses
// 4 upward; rsp_last marks the final beat. A frequency at or above the
// crystal gives an all-ones word.
// csr_valid / csr_ready / csr_wdata write crystal_hz (reset 200000000);
// csr_ready is always high. Write only while the block is idle.
// Sequencing: the back end divides one quotient bit per cycle. An item is
// loaded in IDLE, the band beat leaves from BAND, then each word byte takes
// 8 division steps and its beat (a single step when saturated). The back
// end loads its next item only after the last beat, while the two-entry
// queue takes new items meanwhile. A stalled receiver holds the current beat;
// the back end stops after its next byte is ready, and req_full rises when
// the queue fills.
// Synchronous reset empties the queue and result register and restores
// crystal_hz.
`default_nettype none
module dds_tuning_word_and_band_select_core #(
   parameter int WORD_BYTES = 6
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_push,
   output logic                                 req_full,
   input  wire  [dds_tw_pkg::FREQ_W-1:0]        req_freq_hz,
   output logic                                 rsp_empty,
   input  wire                                  rsp_pop,
   output logic                                 rsp_target,
   output logic [dds_tw_pkg::ADDR_W-1:0]        rsp_reg_addr,
   output logic [dds_tw_pkg::BYTE_W-1:0]        rsp_data_byte,
   output logic                                 rsp_last,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [dds_tw_pkg::CRYSTAL_W-1:0]     csr_wdata
);

   logic [dds_tw_pkg::CRYSTAL_W-1:0] crystal_hz;
   dds_tw_pkg::entry_type            front_entry;
   dds_tw_pkg::entry_type            back_entry;
   dds_tw_pkg::queue_ctl_type        q_ctl;
   logic                             q_pop;

   dds_tw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .freq_hz    (req_freq_hz),
      .crystal_hz (crystal_hz),
      .entry      (front_entry)
   );

   dds_tw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .full     (req_full),
      .wr_entry (front_entry),
      .ctl_out  (q_ctl),
      .pop      (q_pop),
      .rd_entry (back_entry)
   );

   dds_tw_back #(
      .WORD_BYTES (WORD_BYTES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .crystal_hz    (crystal_hz),
      .q_ctl         (q_ctl),
      .q_entry       (back_entry),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_target    (rsp_target),
      .rsp_reg_addr  (rsp_reg_addr),
      .rsp_data_byte (rsp_data_byte),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire

FILE: rtl/dds_tw_checker.sv
// Port-level assertions for the DDS tuning word core, with its bind.
`default_nettype none
module dds_tw_checker #(
   parameter int WORD_BYTES = 6
) (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 rsp_empty,
   input wire                                 rsp_pop,
   input wire                                 rsp_target,
   input wire [dds_tw_pkg::ADDR_W-1:0]        rsp_reg_addr,
   input wire [dds_tw_pkg::BYTE_W-1:0]        rsp_data_byte,
   input wire                                 rsp_last
);

   localparam logic [dds_tw_pkg::ADDR_W-1:0] LAST_ADDR =
      dds_tw_pkg::ADDR_W'(4 + WORD_BYTES - 1);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_latch_beat: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_target == dds_tw_pkg::TARGET_LATCH) |->
         (rsp_reg_addr == dds_tw_pkg::LATCH_ADDR && !rsp_last &&
          $onehot(rsp_data_byte[5:0]) && rsp_data_byte[7:6] == 2'b00))
      else $error("malformed band latch beat");

   a_dds_beat: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_target == dds_tw_pkg::TARGET_DDS) |->
         (rsp_reg_addr >= dds_tw_pkg::FIRST_DDS_ADDR && rsp_reg_addr <= LAST_ADDR &&
          rsp_last == (rsp_reg_addr == LAST_ADDR)))
      else $error("DDS beat address or last flag wrong");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_target) && $stable(rsp_reg_addr) &&
          $stable(rsp_data_byte) && $stable(rsp_last)))
      else $error("stalled result beat changed");

endmodule

bind dds_tuning_word_and_band_select_core dds_tw_checker #(
   .WORD_BYTES (WORD_BYTES)
) u_dds_tw_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_target    (rsp_target),
   .rsp_reg_addr  (rsp_reg_addr),
   .rsp_data_byte (rsp_data_byte),
   .rsp_last      (rsp_last)
);
`default_nettype wire

FILE: verif/tb_dds_tuning_word_and_band_select_core.sv
// Testbench for the DDS tuning word and band select core: scoreboard and stimulus.
`default_nettype none
module tb_dds_tuning_word_and_band_select_core;

   localparam int WORD_BYTES  = 6;
   localparam int QUIET_LIMIT = 3000;
   localparam int MAX_REPORTS = 10;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 12;

   typedef struct packed {
      logic                          target;
      logic [dds_tw_pkg::ADDR_W-1:0] addr;
      logic [dds_tw_pkg::BYTE_W-1:0] data;
      logic                          last;
   } write_beat_type;

   class dds_write_scoreboard_type;
      logic [dds_tw_pkg::CRYSTAL_W-1:0] crystal;
      write_beat_type                   pending_writes[$];
      int                               errors;

      function new();
         crystal = dds_tw_pkg::CRYSTAL_RESET;
         errors  = 0;
      endfunction

      function void set_crystal(logic [dds_tw_pkg::CRYSTAL_W-1:0] value);
         crystal = value;
      endfunction

      function int outstanding();
         return pending_writes.size();
      endfunction

      // band latch beat, then the quotient bytes MSB first
      function void note_freq(logic [dds_tw_pkg::FREQ_W-1:0] f);
         logic [dds_tw_pkg::BAND_W-1:0] band;
         logic [31:0]                   rem;
         logic [dds_tw_pkg::BYTE_W-1:0] qbyte;
         logic                          sat;
         write_beat_type                w;
         if (f <= dds_tw_pkg::BAND_T0) band = dds_tw_pkg::BAND_0;
         else if (f <= dds_tw_pkg::BAND_T1) band = dds_tw_pkg::BAND_1;
         else if (f <= dds_tw_pkg::BAND_T2) band = dds_tw_pkg::BAND_3;
         else if (f <= dds_tw_pkg::BAND_T3) band = dds_tw_pkg::BAND_2;
         else if (f <= dds_tw_pkg::BAND_T4) band = dds_tw_pkg::BAND_4;
         else band = dds_tw_pkg::BAND_5;
         w.target = dds_tw_pkg::TARGET_LATCH;
         w.addr   = dds_tw_pkg::LATCH_ADDR;
         w.data   = {{(dds_tw_pkg::BYTE_W-dds_tw_pkg::BAND_W){1'b0}}, band};
         w.last   = 1'b0;
         pending_writes.push_back(w);
         sat = ({{(dds_tw_pkg::CRYSTAL_W-dds_tw_pkg::FREQ_W){1'b0}}, f} >= crystal);
         rem = {{(32-dds_tw_pkg::FREQ_W){1'b0}}, f};
         for (int i = 0; i < WORD_BYTES; i++) begin
            qbyte = '0;
            if (sat) begin
               qbyte = '1;
            end else begin
               for (int b = 0; b < dds_tw_pkg::BYTE_W; b++) begin
                  rem   = rem << 1;
                  qbyte = qbyte << 1;
                  if (rem >= {2'b00, crystal}) begin
                     rem      = rem - {2'b00, crystal};
                     qbyte[0] = 1'b1;
                  end
               end
            end
            w.target = dds_tw_pkg::TARGET_DDS;
            w.addr   = dds_tw_pkg::FIRST_DDS_ADDR + dds_tw_pkg::ADDR_W'(i);
            w.data   = qbyte;
            w.last   = (i == WORD_BYTES - 1);
            pending_writes.push_back(w);
         end
      endfunction

      function void check_write(write_beat_type got);
         write_beat_type want;
         if (pending_writes.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected beat: target %0d addr %0d data %02h last %0d",
                        got.target, got.addr, got.data, got.last);
            return;
         end
         want = pending_writes.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display({"mismatch: expected target %0d addr %0d data %02h last %0d,",
                         " got target %0d addr %0d data %02h last %0d"},
                        want.target, want.addr, want.data, want.last,
                        got.target, got.addr, got.data, got.last);
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_push = 1'b0;
   logic                             req_full;
   logic [dds_tw_pkg::FREQ_W-1:0]    req_freq_hz = '0;
   logic                             rsp_empty;
   logic                             rsp_pop = 1'b0;
   logic                             rsp_target;
   logic [dds_tw_pkg::ADDR_W-1:0]    rsp_reg_addr;
   logic [dds_tw_pkg::BYTE_W-1:0]    rsp_data_byte;
   logic                             rsp_last;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [dds_tw_pkg::CRYSTAL_W-1:0] csr_wdata = '0;

   dds_write_scoreboard_type sb;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;

   localparam logic [dds_tw_pkg::FREQ_W-1:0] THRESHOLDS [5] = '{
      dds_tw_pkg::BAND_T0, dds_tw_pkg::BAND_T1, dds_tw_pkg::BAND_T2,
      dds_tw_pkg::BAND_T3, dds_tw_pkg::BAND_T4
   };

   dds_tuning_word_and_band_select_core #(.WORD_BYTES(WORD_BYTES)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_freq_hz  (req_freq_hz),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_target   (rsp_target),
      .rsp_reg_addr (rsp_reg_addr),
      .rsp_data_byte(rsp_data_byte),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // beat monitor, receiver stalls and activity count
   always @(posedge clock) begin
      logic moved;
      if (reset) begin
         rsp_pop <= 1'b0;
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (req_push && !req_full) begin
            sb.note_freq(req_freq_hz);
            moved = 1'b1;
         end
         if (csr_valid && csr_ready) moved = 1'b1;
         if (rsp_pop && !rsp_empty) begin
            sb.check_write({rsp_target, rsp_reg_addr, rsp_data_byte, rsp_last});
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic push_freq(input logic [dds_tw_pkg::FREQ_W-1:0] f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_freq_hz <= f;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic drain_writes();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_crystal(input logic [dds_tw_pkg::CRYSTAL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_crystal(value);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [dds_tw_pkg::FREQ_W-1:0] random_freq();
      logic [dds_tw_pkg::FREQ_W-1:0] f;
      case ($urandom_range(3))
         0: f = dds_tw_pkg::FREQ_W'($urandom);
         1: begin
            if (sb.crystal > 1 && sb.crystal <= (1 << dds_tw_pkg::FREQ_W))
               f = dds_tw_pkg::FREQ_W'($urandom % sb.crystal);
            else
               f = dds_tw_pkg::FREQ_W'($urandom);
         end
         2: f = THRESHOLDS[$urandom_range(4)] + dds_tw_pkg::FREQ_W'($urandom_range(4))
                - dds_tw_pkg::FREQ_W'(2);
         default: f = dds_tw_pkg::FREQ_W'($urandom_range(4096));
      endcase
      return f;
   endfunction

   initial begin
      logic [dds_tw_pkg::CRYSTAL_W-1:0] xtal;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // band edges at the reset crystal
      push_freq('0);
      push_freq(dds_tw_pkg::FREQ_W'(1));
      foreach (THRESHOLDS[k]) begin
         push_freq(THRESHOLDS[k]);
         push_freq(THRESHOLDS[k] + dds_tw_pkg::FREQ_W'(1));
      end
      push_freq('1);
      push_freq(dds_tw_pkg::FREQ_W'(27'h5555555));
      push_freq(dds_tw_pkg::FREQ_W'(27'h2AAAAAA));
      drain_writes();

      // saturation around the crystal
      write_crystal(dds_tw_pkg::CRYSTAL_W'(1000000));
      push_freq(dds_tw_pkg::FREQ_W'(999999));
      push_freq(dds_tw_pkg::FREQ_W'(1000000));
      push_freq(dds_tw_pkg::FREQ_W'(1000001));
      push_freq('1);
      drain_writes();

      // zero crystal saturates everything
      write_crystal('0);
      push_freq('0);
      push_freq(dds_tw_pkg::FREQ_W'(1));
      push_freq('1);
      drain_writes();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: xtal = dds_tw_pkg::CRYSTAL_W'(200000000);
            1: xtal = dds_tw_pkg::CRYSTAL_W'(1000000000);
            2: xtal = '1;
            3: xtal = dds_tw_pkg::CRYSTAL_W'(1000000);
            4: xtal = dds_tw_pkg::CRYSTAL_W'($urandom);
            5: xtal = dds_tw_pkg::CRYSTAL_W'($urandom_range(1000000000, 1000000));
            6: xtal = dds_tw_pkg::CRYSTAL_W'($urandom_range(134217727, 1000000));
            default: xtal = dds_tw_pkg::CRYSTAL_W'(200000000);
         endcase
         write_crystal(xtal);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) push_freq(random_freq());
         drain_writes();
      end

      repeat (80) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
